@@ rtl/smb_pkg.sv @@
// ---------------------------------------------------------------------------
// smb_pkg: shared types and constants for the soil moisture balance step
// Sequencer states, register indexes and the factor table helper.
// ---------------------------------------------------------------------------
package smb_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_RATIO,
      ST_NORM,
      ST_LOG_MUL,
      ST_LOG_ACC,
      ST_BETA_MUL,
      ST_BETA_ACC,
      ST_POW_MUL,
      ST_POW_ACC,
      ST_POW_END,
      ST_GW_MUL,
      ST_GW_ACC,
      ST_LIM_MUL,
      ST_LIM_ACC,
      ST_EV_MUL,
      ST_EV_ACC,
      ST_EV_DIV,
      ST_BAL
   } state_type;

   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_BETA     = 2'd1;
   localparam logic [1:0] CSR_LP       = 2'd2;

   localparam logic [18:0] CAPACITY_RST = 19'd51200;
   localparam logic [10:0] BETA_RST     = 11'd512;
   localparam logic [8:0]  LP_RST       = 9'd179;

   localparam int unsigned EVAP_W  = 14;
   localparam int unsigned WATER_W = 17;
   localparam int unsigned STORE_W = 19;
   localparam int unsigned LIM_W   = 28;

   localparam logic [WATER_W-1:0] WATER_MAX = '1;

   // integer square root, elaboration use only
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] rem;
      r   = '0;
      rem = v;
      b   = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-2^-k) with f fraction bits, each root truncated
   function automatic logic [63:0] pow_factor(input int unsigned f, input int unsigned k);
      logic [63:0] d;
      d = 64'd1 << (f - 1);
      for (int unsigned j = 1; j <= k; j++) begin
         d = isqrt64(d << f);
      end
      return d;
   endfunction

endpackage

@@ rtl/soil_moisture_balance_step.sv @@
// ---------------------------------------------------------------------------
// soil_moisture_balance_step: soil moisture routine, one time step per word
// Splits infiltration into groundwater and soil shares, reduces evaporation
// by soil dryness and keeps the moisture store, in 1/256 mm fixed point.
// ---------------------------------------------------------------------------
//  channel | dir | fields (low bit first)
//  req     | in  | tdata: infiltration 17, potential_evap 14
//  rsp     | out | tdata: actual_evap 14, groundwater_recharge 17,
//          |     |        soil_recharge 17, new_moisture 19
//  csr     | in  | index 0 capacity, 1 beta, 2 LP; write only
//
//  Words are taken one at a time (F = POWER_FRAC_BITS); the time per word is set
//  by the bit-serial ratio and evaporation divisions and by the 2F log and power
//  steps through the single shared multiplier.
//  Reset clears the moisture store and loads the register defaults.
//  A new word is taken only in idle; a finished word waits in the output
//  register, and the next word may run up to its last cycle meanwhile.
// ---------------------------------------------------------------------------
module soil_moisture_balance_step
   import smb_pkg::*;
#(
   parameter int unsigned POWER_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // infiltration, potential_evap
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // actual_evap, groundwater_recharge,
                                    // soil_recharge, new_moisture
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [18:0] csr_wdata
);

   localparam int unsigned F   = POWER_FRAC_BITS;
   localparam int unsigned KW  = $clog2(F + 1);
   localparam int unsigned DIW = $clog2(F);
   localparam int unsigned LW  = KW + F;
   localparam int unsigned AW  = (F + 1 > WATER_W) ? F + 1 : WATER_W;
   localparam int unsigned BW  = (LW > STORE_W) ? LW : STORE_W;
   localparam int unsigned PW  = AW + BW;
   localparam int unsigned QW  = (F > EVAP_W) ? F : EVAP_W;
   localparam logic [F:0]  ONE = {1'b1, {F{1'b0}}};

   state_type state_ff, state_in;

   logic [STORE_W-1:0] cap_ff, cap_in;
   logic [10:0]        beta_ff, beta_in;
   logic [8:0]         lp_ff, lp_in;
   logic [STORE_W-1:0] sm_ff, sm_in;

   logic [WATER_W-1:0] inf_ff, inf_in;
   logic [EVAP_W-1:0]  epot_ff, epot_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [KW-1:0]      cnt_ff, cnt_in;
   logic [F:0]         x_ff, x_in;
   logic [F-1:0]       frac_ff, frac_in;
   logic [F:0]         p_ff, p_in;
   logic [F:0]         pw_ff, pw_in;
   logic               ipbig_ff, ipbig_in;
   logic [KW-1:0]      ipsh_ff, ipsh_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [LIM_W-1:0]   rem_ff, rem_in;
   logic [LIM_W-1:0]   den_ff, den_in;
   logic [EVAP_W-1:0]  bits_ff, bits_in;
   logic [QW-1:0]      quo_ff, quo_in;
   logic [EVAP_W-1:0]  eact_ff, eact_in;
   logic [WATER_W-1:0] gw_ff, gw_in;
   logic [WATER_W-1:0] soil_ff, soil_in;

   logic               rvalid_ff, rvalid_in;
   logic [EVAP_W-1:0]  revap_ff, revap_in;
   logic [WATER_W-1:0] rgw_ff, rgw_in;
   logic [WATER_W-1:0] rsoil_ff, rsoil_in;

   logic [AW-1:0]      mul_a;
   logic [BW-1:0]      mul_b;
   logic [F-1:0]       d_tab [F];
   logic [LW-1:0]      lval;
   logic [LIM_W:0]     div_t;
   logic               div_ge;
   logic [LIM_W-1:0]   div_r;
   logic [F+1:0]       sq;
   logic [WATER_W-1:0] gwp;
   logic               out_free;
   logic               req_acc;
   logic signed [20:0] bal_t;
   logic [19:0]        bal_ovf;
   logic [20:0]        bal_gsum;
   logic [F-1:0]       ratio;

   // power factors 2^(-2^-(gi+1)), built at elaboration
   for (genvar gi = 0; gi < F; gi++) begin : g_dtab
      localparam logic [63:0] DV = pow_factor(F, gi + 1);
      assign d_tab[gi] = DV[F-1:0];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rvalid_ff || rsp_tready;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {5'b0, sm_ff, rsoil_ff, rgw_ff, revap_ff};

   assign lval   = {cnt_ff, {F{1'b0}}} - LW'(frac_ff);
   assign div_t  = {rem_ff, bits_ff[EVAP_W-1]};
   assign div_ge = div_t >= {1'b0, den_ff};
   assign div_r  = div_ge ? LIM_W'(div_t - {1'b0, den_ff}) : div_t[LIM_W-1:0];
   assign sq     = prod_ff[2*F+1:F];
   assign gwp    = prod_ff[F+WATER_W-1:F];
   assign ratio  = quo_ff[F-1:0];

   // shared multiplier, product always registered
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LOG_MUL: begin
            mul_a = AW'(x_ff);
            mul_b = BW'(x_ff);
         end
         ST_BETA_MUL: begin
            mul_a = AW'(beta_ff);
            mul_b = BW'(lval);
         end
         ST_POW_MUL: begin
            mul_a = AW'(p_ff);
            mul_b = BW'(d_tab[k_ff[DIW-1:0]]);
         end
         ST_GW_MUL: begin
            mul_a = AW'(inf_ff);
            mul_b = BW'(pw_ff);
         end
         ST_LIM_MUL: begin
            mul_a = AW'(lp_ff);
            mul_b = BW'(cap_ff);
         end
         ST_EV_MUL: begin
            mul_a = AW'(epot_ff);
            mul_b = BW'(sm_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_acc) state_in = ST_START;
         ST_START: begin
            if (sm_ff == '0)         state_in = ST_GW_MUL;
            else if (sm_ff >= cap_ff) state_in = ST_NORM;
            else                      state_in = ST_RATIO;
         end
         ST_RATIO: begin
            if (k_ff == KW'(F)) state_in = (ratio == '0) ? ST_GW_MUL : ST_NORM;
         end
         ST_NORM:     if (x_ff[F]) state_in = ST_LOG_MUL;
         ST_LOG_MUL:  state_in = ST_LOG_ACC;
         ST_LOG_ACC:  state_in = (k_ff == KW'(F - 1)) ? ST_BETA_MUL : ST_LOG_MUL;
         ST_BETA_MUL: state_in = ST_BETA_ACC;
         ST_BETA_ACC: state_in = ST_POW_MUL;
         ST_POW_MUL: begin
            if (frac_ff[F-1])             state_in = ST_POW_ACC;
            else if (k_ff == KW'(F - 1)) state_in = ST_POW_END;
         end
         ST_POW_ACC:  state_in = (k_ff == KW'(F - 1)) ? ST_POW_END : ST_POW_MUL;
         ST_POW_END:  state_in = ST_GW_MUL;
         ST_GW_MUL:   state_in = ST_GW_ACC;
         ST_GW_ACC:   state_in = ST_LIM_MUL;
         ST_LIM_MUL:  state_in = ST_LIM_ACC;
         ST_LIM_ACC: begin
            if ({sm_ff, 8'b0} >= {1'b0, prod_ff[LIM_W-1:0]}) state_in = ST_BAL;
            else                                              state_in = ST_EV_MUL;
         end
         ST_EV_MUL:   state_in = ST_EV_ACC;
         ST_EV_ACC:   state_in = ST_EV_DIV;
         ST_EV_DIV:   if (k_ff == KW'(EVAP_W)) state_in = ST_BAL;
         ST_BAL:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cap_in   = cap_ff;
      beta_in  = beta_ff;
      lp_in    = lp_ff;
      sm_in    = sm_ff;
      inf_in   = inf_ff;
      epot_in  = epot_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      frac_in  = frac_ff;
      p_in     = p_ff;
      pw_in    = pw_ff;
      ipbig_in = ipbig_ff;
      ipsh_in  = ipsh_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      bits_in  = bits_ff;
      quo_in   = quo_ff;
      eact_in  = eact_ff;
      gw_in    = gw_ff;
      soil_in  = soil_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      revap_in = revap_ff;
      rgw_in   = rgw_ff;
      rsoil_in = rsoil_ff;
      bal_t    = '0;
      bal_ovf  = '0;
      bal_gsum = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY: cap_in  = csr_wdata;
            CSR_BETA:     beta_in = csr_wdata[10:0];
            CSR_LP:       lp_in   = csr_wdata[8:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            inf_in  = req_tdata[WATER_W-1:0];
            epot_in = req_tdata[WATER_W+EVAP_W-1:WATER_W];
         end
         ST_START: begin
            pw_in  = '0;
            x_in   = ONE;
            cnt_in = '0;
            rem_in = LIM_W'(sm_ff);
            den_in = LIM_W'(cap_ff);
            bits_in = '0;
            quo_in = '0;
            k_in   = '0;
         end
         ST_RATIO: begin
            if (k_ff == KW'(F)) begin
               pw_in  = '0;
               x_in   = {1'b0, ratio};
               cnt_in = '0;
            end else begin
               rem_in  = div_r;
               quo_in  = {quo_ff[QW-2:0], div_ge};
               bits_in = {bits_ff[EVAP_W-2:0], 1'b0};
               k_in    = k_ff + 1'b1;
            end
         end
         ST_NORM: begin
            if (x_ff[F]) begin
               k_in    = '0;
               frac_in = '0;
            end else begin
               x_in   = {x_ff[F-1:0], 1'b0};
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LOG_ACC: begin
            // square lands in [1,4): one more log bit per step
            x_in    = sq[F+1] ? sq[F+1:1] : sq[F:0];
            frac_in = {frac_ff[F-2:0], sq[F+1]};
            k_in    = k_ff + 1'b1;
         end
         ST_BETA_ACC: begin
            frac_in  = prod_ff[F+7:8];
            ipsh_in  = prod_ff[F+8+KW-1:F+8];
            ipbig_in = (|prod_ff[PW-1:F+8+KW]) || (prod_ff[F+8+KW-1:F+8] > KW'(F));
            p_in     = ONE;
            k_in     = '0;
         end
         ST_POW_MUL: begin
            if (!frac_ff[F-1]) begin
               frac_in = {frac_ff[F-2:0], 1'b0};
               k_in    = k_ff + 1'b1;
            end
         end
         ST_POW_ACC: begin
            p_in    = prod_ff[2*F:F];
            frac_in = {frac_ff[F-2:0], 1'b0};
            k_in    = k_ff + 1'b1;
         end
         ST_POW_END: begin
            pw_in = ipbig_ff ? '0 : (p_ff >> ipsh_ff);
         end
         ST_GW_ACC: begin
            gw_in   = (gwp > inf_ff) ? inf_ff : gwp;
            soil_in = inf_ff - ((gwp > inf_ff) ? inf_ff : gwp);
         end
         ST_LIM_ACC: begin
            den_in  = prod_ff[LIM_W-1:0];
            eact_in = epot_ff;
         end
         ST_EV_ACC: begin
            // numerator epot*sm*256, top part already below the limit
            rem_in  = LIM_W'(prod_ff[32:6]);
            bits_in = {prod_ff[5:0], 8'b0};
            quo_in  = '0;
            k_in    = '0;
         end
         ST_EV_DIV: begin
            if (k_ff == KW'(EVAP_W)) begin
               eact_in = quo_ff[EVAP_W-1:0];
            end else begin
               rem_in  = div_r;
               quo_in  = {quo_ff[QW-2:0], div_ge};
               bits_in = {bits_ff[EVAP_W-2:0], 1'b0};
               k_in    = k_ff + 1'b1;
            end
         end
         ST_BAL: begin
            bal_t = 21'(soil_ff) + 21'(sm_ff) - 21'(eact_ff);
            if (out_free) begin
               rvalid_in = 1'b1;
               rsoil_in  = soil_ff;
               revap_in  = eact_ff;
               rgw_in    = gw_ff;
               if (bal_t > $signed(21'(cap_ff))) begin
                  bal_ovf  = 20'(bal_t - $signed(21'(cap_ff)));
                  bal_gsum = 21'(gw_ff) + 21'(bal_ovf);
                  rgw_in   = (bal_gsum > 21'(WATER_MAX)) ? WATER_MAX
                                                          : bal_gsum[WATER_W-1:0];
                  sm_in    = cap_ff;
               end else if (bal_t < 0) begin
                  revap_in = EVAP_W'(20'(soil_ff) + 20'(sm_ff));
                  sm_in    = '0;
               end else begin
                  sm_in = bal_t[STORE_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cap_ff    <= CAPACITY_RST;
         beta_ff   <= BETA_RST;
         lp_ff     <= LP_RST;
         sm_ff     <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cap_ff    <= cap_in;
         beta_ff   <= beta_in;
         lp_ff     <= lp_in;
         sm_ff     <= sm_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      inf_ff   <= inf_in;
      epot_ff  <= epot_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      x_ff     <= x_in;
      frac_ff  <= frac_in;
      p_ff     <= p_in;
      pw_ff    <= pw_in;
      ipbig_ff <= ipbig_in;
      ipsh_ff  <= ipsh_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      bits_ff  <= bits_in;
      quo_ff   <= quo_in;
      eact_ff  <= eact_in;
      gw_ff    <= gw_in;
      soil_ff  <= soil_in;
      revap_ff <= revap_in;
      rgw_ff   <= rgw_in;
      rsoil_ff <= rsoil_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_START)
      else $error("accepted word did not start the sequencer");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RATIO || state_ff == ST_EV_DIV) |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_power_le_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GW_MUL |-> pw_ff <= ONE)
      else $error("power above one");

   a_bal_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BAL && rvalid_ff && !rsp_tready) |=> state_ff == ST_BAL)
      else $error("result left while output register busy");

endmodule
